// File: sv/spd_pkg.sv
// Shared types and codes for the sensor packet deframer.
// No dependencies; every other file refers to this package by scoped names.
package spd_pkg;

    // Input command codes (tuser on the input side)
    localparam logic [1:0] CMD_BYTE    = 2'd0;
    localparam logic [1:0] CMD_TICK    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // Result status codes (tuser on the output side)
    localparam logic [1:0] ST_PAYLOAD   = 2'd0;
    localparam logic [1:0] ST_BAD_START = 2'd1;
    localparam logic [1:0] ST_TIMEOUT   = 2'd2;

    // Configuration register indexes
    localparam logic REG_SYNC_WORD     = 1'b0;
    localparam logic REG_TIMEOUT_TICKS = 1'b1;

    localparam logic [15:0] SYNC_WORD_RST     = 16'hEF01;
    localparam logic [31:0] TIMEOUT_TICKS_RST = 32'd5000;

    typedef enum logic [9:0] {
        PH_HUNT     = 10'b00_0000_0001,
        PH_START_LO = 10'b00_0000_0010,
        PH_ADDR0    = 10'b00_0000_0100,
        PH_ADDR1    = 10'b00_0000_1000,
        PH_ADDR2    = 10'b00_0001_0000,
        PH_ADDR3    = 10'b00_0010_0000,
        PH_TYPE     = 10'b00_0100_0000,
        PH_LEN_HI   = 10'b00_1000_0000,
        PH_LEN_LO   = 10'b01_0000_0000,
        PH_PAYLOAD  = 10'b10_0000_0000
    } phase_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  data_byte;
        logic [15:0] byte_number;
        logic [7:0]  packet_type;
        logic [31:0] address;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [15:0] sync_word;
        logic [31:0] timeout_ticks;
    } cfg_t;

endpackage

// File: sv/sensor_packet_deframer_core.sv
// Sensor packet deframer, top level. Takes received UART bytes, idle ticks and
// restart commands and pulls packets out of them: it hunts for the high byte of
// the start code, checks the low byte (a mismatch gives a bad-start result),
// captures a 4-byte address (first byte most significant), a type byte and a
// 16-bit length (high byte first), then streams each payload byte out with its
// position, the type and the address, marking as last the byte whose position
// equals the length. Idle ticks count over the whole packet, hunting included;
// reaching timeout_ticks gives a timeout result. Any end, and a restart, re-arms
// the hunt. Checksum bytes pass unchecked. A length of zero never completes; it
// ends only by timeout or restart, and the byte count saturates at 65535.
// Rate: one item per clock while the output slot is free; a result held by a
// low m_tready stalls the next item that gives a result. An accepted item sits
// in the input register, the parser settles it in one pass and its result, if
// any, is loaded into the output register, which raises m_tvalid. Items that
// give no result never wait for the output slot. The user must write
// configuration only while no item is in flight; the block itself does not
// enforce it. There is no clearing pass after reset.
// Depends on spd_pkg, spd_in_stage, spd_parse and spd_out_stage.
module sensor_packet_deframer_core (
    input  logic        clk,
    input  logic        rst_n,

    // configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,     // 0 sync_word, 1 timeout_ticks
    input  logic [31:0] cfg_data,

    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] rx_byte
    input  logic [1:0]  s_tuser,      // [1:0] cmd

    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,      // [7:0] data_byte, [23:8] byte_number,
                                      // [31:24] packet_type, [63:32] address
    output logic [1:0]  m_tuser,      // [1:0] status
    output logic        m_tlast       // last
);

    spd_pkg::cfg_t     cfg_reg;
    spd_pkg::in_item_t in_item;
    spd_pkg::in_item_t item;
    spd_pkg::result_t  res;
    spd_pkg::result_t  out_res;
    logic              item_valid;
    logic              fire;
    logic              res_valid;
    logic              room;

    // Configuration registers: written on any cycle cfg_wr_en is high
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_word     <= spd_pkg::SYNC_WORD_RST;
            cfg_reg.timeout_ticks <= spd_pkg::TIMEOUT_TICKS_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                spd_pkg::REG_SYNC_WORD:     cfg_reg.sync_word     <= cfg_data[15:0];
                spd_pkg::REG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= cfg_data;
                default:                    ;
            endcase
        end
    end

    assign in_item.cmd     = s_tuser;
    assign in_item.rx_byte = s_tdata;

    // Hold the accepted item in a register ahead of the parser
    spd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .pop        (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    // Advance the frame state and form the result in one pass
    spd_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .cfg        (cfg_reg),
        .out_room   (room),
        .fire       (fire),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Park the result until the sink takes it
    spd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire && res_valid),
        .res       (res),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {out_res.address, out_res.packet_type,
                      out_res.byte_number, out_res.data_byte};
    assign m_tuser = out_res.status;
    assign m_tlast = out_res.last;

endmodule

// File: sv/spd_in_stage.sv
// Input register of the sensor packet deframer.
// Depends on spd_pkg for the item type.
module spd_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  spd_pkg::in_item_t in_item,
    input  logic              pop,
    output logic              item_valid,
    output spd_pkg::in_item_t item
);

    logic              valid_reg;
    logic              valid_next;
    spd_pkg::in_item_t item_reg;

    // Take a new item when empty or whenever the held one leaves this cycle
    assign in_ready = !valid_reg || pop;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: sv/spd_parse.sv
// Frame parser of the sensor packet deframer: phase, captured header and timer.
// Depends on spd_pkg for codes, the phase type and the item/result structs.
module spd_parse (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  spd_pkg::in_item_t item,
    input  spd_pkg::cfg_t     cfg,
    input  logic              out_room,
    output logic              fire,
    output logic              res_valid,
    output spd_pkg::result_t  res
);

    spd_pkg::phase_t phase_reg;
    spd_pkg::phase_t phase_next;
    logic [31:0]     addr_reg;
    logic [31:0]     addr_next;
    logic [7:0]      type_reg;
    logic [7:0]      type_next;
    logic [15:0]     length_reg;
    logic [15:0]     length_next;
    logic [15:0]     count_reg;
    logic [15:0]     count_next;
    logic [31:0]     timer_reg;
    logic [31:0]     timer_next;
    logic [31:0]     timer_inc;
    logic [15:0]     count_inc;
    logic            hunt_hit;
    logic            done;

    // Saturating increments
    assign timer_inc = (timer_reg == '1) ? timer_reg : timer_reg + 32'd1;
    assign count_inc = (count_reg == '1) ? count_reg : count_reg + 16'd1;
    assign hunt_hit  = (item.rx_byte == cfg.sync_word[15:8]);
    assign done      = (count_inc == length_reg);

    always_comb
    begin
        phase_next  = phase_reg;
        addr_next   = addr_reg;
        type_next   = type_reg;
        length_next = length_reg;
        count_next  = count_reg;
        timer_next  = timer_reg;
        res_valid   = 1'b0;
        res         = '0;
        case (item.cmd)
            spd_pkg::CMD_RESTART:
            begin
                phase_next = spd_pkg::PH_HUNT;
                timer_next = '0;
                count_next = '0;
            end
            spd_pkg::CMD_TICK:
            begin
                timer_next = timer_inc;
                if (timer_inc >= cfg.timeout_ticks)
                begin
                    phase_next = spd_pkg::PH_HUNT;
                    timer_next = '0;
                    res_valid  = 1'b1;
                    res.status = spd_pkg::ST_TIMEOUT;
                end
            end
            spd_pkg::CMD_BYTE:
            begin
                case (phase_reg)
                    spd_pkg::PH_START_LO:
                    begin
                        if (item.rx_byte != cfg.sync_word[7:0])
                        begin
                            phase_next = spd_pkg::PH_HUNT;
                            timer_next = '0;
                            res_valid  = 1'b1;
                            res.status = spd_pkg::ST_BAD_START;
                        end
                        else
                        begin
                            phase_next = spd_pkg::PH_ADDR0;
                        end
                    end
                    spd_pkg::PH_ADDR0, spd_pkg::PH_ADDR1, spd_pkg::PH_ADDR2,
                    spd_pkg::PH_ADDR3:
                    begin
                        addr_next = {addr_reg[23:0], item.rx_byte};
                        case (phase_reg)
                            spd_pkg::PH_ADDR0: phase_next = spd_pkg::PH_ADDR1;
                            spd_pkg::PH_ADDR1: phase_next = spd_pkg::PH_ADDR2;
                            spd_pkg::PH_ADDR2: phase_next = spd_pkg::PH_ADDR3;
                            default:           phase_next = spd_pkg::PH_TYPE;
                        endcase
                    end
                    spd_pkg::PH_TYPE:
                    begin
                        type_next  = item.rx_byte;
                        phase_next = spd_pkg::PH_LEN_HI;
                    end
                    spd_pkg::PH_LEN_HI:
                    begin
                        length_next = {item.rx_byte, 8'h00};
                        phase_next  = spd_pkg::PH_LEN_LO;
                    end
                    spd_pkg::PH_LEN_LO:
                    begin
                        length_next = {length_reg[15:8], item.rx_byte};
                        count_next  = '0;
                        phase_next  = spd_pkg::PH_PAYLOAD;
                    end
                    spd_pkg::PH_PAYLOAD:
                    begin
                        count_next      = count_inc;
                        res_valid       = 1'b1;
                        res.status      = spd_pkg::ST_PAYLOAD;
                        res.data_byte   = item.rx_byte;
                        res.byte_number = count_inc;
                        res.packet_type = type_reg;
                        res.address     = addr_reg;
                        res.last        = done;
                        if (done)
                        begin
                            phase_next = spd_pkg::PH_HUNT;
                            timer_next = '0;
                        end
                    end
                    default:
                    begin
                        // hunting, and any stray code: look for the high start byte
                        phase_next = hunt_hit ? spd_pkg::PH_START_LO : spd_pkg::PH_HUNT;
                    end
                endcase
            end
            default:
            begin
                // unused command: drop it
            end
        endcase
    end

    // An item without a result never waits for the output slot
    assign fire = item_valid && (out_room || !res_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= spd_pkg::PH_HUNT;
            addr_reg   <= '0;
            type_reg   <= '0;
            length_reg <= '0;
            count_reg  <= '0;
            timer_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            addr_reg   <= addr_next;
            type_reg   <= type_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            timer_reg  <= timer_next;
        end
    end

    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(phase_reg))
        else $error("phase register lost its one-hot code");

    a_error_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res_valid && res.status != spd_pkg::ST_PAYLOAD
        |=> phase_reg == spd_pkg::PH_HUNT && timer_reg == '0)
        else $error("error result did not re-arm the hunt");

    a_last_matches_length: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res_valid && res.last |-> res.byte_number == length_reg)
        else $error("last flag on a byte whose count differs from the length");

    a_payload_numbered: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res_valid && res.status == spd_pkg::ST_PAYLOAD
        |-> res.byte_number != '0)
        else $error("payload byte numbered zero");

endmodule

// File: sv/spd_out_stage.sv
// Result register of the sensor packet deframer.
// Depends on spd_pkg for the result struct.
module spd_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  spd_pkg::result_t res,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output spd_pkg::result_t out_res
);

    logic             valid_reg;
    logic             valid_next;
    spd_pkg::result_t res_reg;

    // Free next cycle when empty or being taken now
    assign room = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule
